// ----- src/csm_pkg.sv -----
// Package for the CSR sparse matrix multiply block.
// Holds parameter defaults, field widths, mode codes and the tdata layouts.
package csm_pkg;
  localparam int unsigned MaxColsDef = 64;
  localparam int unsigned MaxBNnzDef = 1024;
  localparam int unsigned ValW = 32;
  localparam int unsigned ColW = 6;
  localparam int unsigned IdxW = 10;
  localparam int unsigned RpW = 11;
  localparam int unsigned CntW = 16;
  localparam int unsigned CfgW = 7;
  localparam logic [1:0] MODE_ROWPTR = 2'd0;
  localparam logic [1:0] MODE_BENT = 2'd1;
  localparam logic [1:0] MODE_AENT = 2'd2;
  localparam logic [1:0] MODE_EOR = 2'd3;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic [ColW-1:0] column;
    logic [RpW-1:0] row_pointer;
    logic [IdxW-1:0] store_index;
    logic [1:0] mode;
  } in_item_t;

  typedef struct packed {
    logic [CntW-1:0] nnz_so_far;
    logic is_entry;
    logic signed [ValW-1:0] out_value;
    logic [ColW-1:0] out_column;
  } out_item_t;
endpackage

// ----- src/csr_sparse_matrix_multiply.sv -----
// CSR sparse product C = A*B, Gustavson row by row, dense accumulator.
// Load: stored on accept. A entry: row start read, then per row B entry: read, multiply, add.
// End of row: read and check per touched column, output per result item, then close the row.
// One item at a time; ready is low while an item is at work or a result waits.
// Sync reset clears control, touch valid bits, list, counts; B stores stay undefined.
// Depends on csm_pkg and csm_ram.
module csr_sparse_matrix_multiply import csm_pkg::*; #(
  parameter int unsigned MAX_COLS  = MaxColsDef,
  parameter int unsigned MAX_B_NNZ = MaxBNnzDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgW-1:0]      cfg_wdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // mode, store_index, row_pointer, column, value; 3 pad bits
  input  logic [63:0]          s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // out_column, out_value, is_entry, nnz_so_far; 1 pad bit
  output logic [55:0]          m_tdata,
  output logic                 m_tlast
);
  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned RW = $clog2(MAX_COLS + 1);
  localparam int unsigned BW = $clog2(MAX_B_NNZ);
  localparam int unsigned PW = $clog2(MAX_B_NNZ + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_RS0 = 4'd1, S_RS1 = 4'd2, S_RS2 = 4'd3,
    S_WRD = 4'd4, S_WMUL = 4'd5, S_WADD = 4'd6, S_FRD = 4'd7, S_FCHK = 4'd8,
    S_OUT = 4'd9, S_CLR = 4'd10;

  in_item_t in_item;
  assign in_item = in_item_t'(s_tdata[$bits(in_item_t)-1:0]);

  logic [3:0] state;
  logic [CfgW-1:0] active_cols;
  logic [CfgW-1:0] eff_cols;
  logic [CW-1:0] a_col;
  logic [ValW-1:0] a_val;
  logic [PW-1:0] kk, kend;
  logic [ColW-1:0] bk;
  logic [ValW-1:0] prod;
  logic [MAX_COLS-1:0] touched;
  logic [CW:0] head;
  logic [CW:0] tcount, fcount;
  logic [CntW-1:0] product_nnz;
  logic emitted;
  out_item_t res;
  out_item_t pend;
  logic res_last;

  assign eff_cols = (active_cols == '0) ? CfgW'(1) :
                    (active_cols > CfgW'(MAX_COLS)) ? CfgW'(MAX_COLS) : active_cols;

  // row start RAM
  logic rs_we;
  logic [RW-1:0] rs_raddr;
  logic [RpW-1:0] rs_rdata;
  csm_ram #(.Width(RpW), .Depth(MAX_COLS + 1)) u_rs (
    .clk, .we(rs_we), .waddr(in_item.store_index[RW-1:0]), .wdata(in_item.row_pointer),
    .raddr(rs_raddr), .rdata(rs_rdata));

  logic b_we;
  logic [ColW-1:0] bc_rdata;
  logic [ValW-1:0] bv_rdata;
  csm_ram #(.Width(ColW), .Depth(MAX_B_NNZ)) u_bc (
    .clk, .we(b_we), .waddr(in_item.store_index[BW-1:0]), .wdata(in_item.column),
    .raddr(kk[BW-1:0]), .rdata(bc_rdata));
  csm_ram #(.Width(ValW), .Depth(MAX_B_NNZ)) u_bv (
    .clk, .we(b_we), .waddr(in_item.store_index[BW-1:0]), .wdata(in_item.value),
    .raddr(kk[BW-1:0]), .rdata(bv_rdata));

  // sums and links
  logic ps_we;
  logic [CW-1:0] ps_waddr, ps_raddr;
  logic [ValW-1:0] ps_wdata, ps_rdata;
  csm_ram #(.Width(ValW), .Depth(MAX_COLS)) u_ps (
    .clk, .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata), .raddr(ps_raddr),
    .rdata(ps_rdata));
  logic lk_we;
  logic [CW:0] lk_rdata;
  csm_ram #(.Width(CW + 1), .Depth(MAX_COLS)) u_lk (
    .clk, .we(lk_we), .waddr(ps_waddr), .wdata(head), .raddr(ps_raddr),
    .rdata(lk_rdata));

  logic accept;
  assign s_tready = (state == S_IDLE);
  assign accept = s_tvalid && s_tready;
  logic idx_ok_rs, idx_ok_b;
  assign idx_ok_rs = {22'd0, in_item.store_index} <= 32'(MAX_COLS);
  assign idx_ok_b = {22'd0, in_item.store_index} < 32'(MAX_B_NNZ);
  assign rs_we = accept && in_item.mode == MODE_ROWPTR && idx_ok_rs;
  assign b_we = accept && in_item.mode == MODE_BENT && idx_ok_b;

  logic bk_ok;
  assign bk_ok = {1'b0, bk} < eff_cols;
  logic [CW-1:0] bk_c, head_c;
  assign bk_c = bk[CW-1:0];
  assign head_c = head[CW-1:0];

  always_comb begin
    rs_raddr = RW'(a_col);
    if (state == S_RS0) rs_raddr = RW'(a_col) + RW'(1);
    ps_raddr = (state == S_FRD || state == S_FCHK || state == S_OUT) ? head_c :
               (state == S_WMUL) ? bc_rdata[CW-1:0] : bk_c;
    ps_we = 1'b0;
    ps_waddr = bk_c;
    // untouched sums count as zero
    ps_wdata = (touched[bk_c] ? ps_rdata : '0) + prod;
    lk_we = 1'b0;
    if (state == S_WADD && bk_ok) begin
      ps_we = 1'b1;
      lk_we = !touched[bk_c];
    end
    if (state == S_FCHK) begin
      ps_we = 1'b1;
      ps_waddr = head_c;
      ps_wdata = '0;
    end
  end

  logic [PW-1:0] rs_ext;
  assign rs_ext = (RpW >= PW) ? ((32'(rs_rdata) > 32'(MAX_B_NNZ)) ? PW'(MAX_B_NNZ)
                               : PW'(rs_rdata)) : PW'(rs_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      active_cols <= CfgW'(64);
      touched <= '0;
      head <= (CW + 1)'(MAX_COLS);
      tcount <= '0;
      product_nnz <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) active_cols <= cfg_wdata;
      case (state)
        S_IDLE: begin
          if (accept) begin
            a_col <= in_item.column[CW-1:0];
            a_val <= in_item.value;
            if (in_item.mode == MODE_AENT &&
                {26'd0, in_item.column} < 32'(MAX_COLS)) begin
              state <= S_RS0;
            end else if (in_item.mode == MODE_EOR) begin
              fcount <= '0;
              emitted <= 1'b0;
              state <= S_FRD;
            end
          end
        end
        S_RS0: state <= S_RS1;
        S_RS1: begin
          kend <= rs_ext;
          state <= S_RS2;
        end
        S_RS2: begin
          kk <= rs_ext;
          state <= (rs_ext < kend) ? S_WRD : S_IDLE;
        end
        S_WRD: state <= S_WMUL;
        S_WMUL: begin
          bk <= bc_rdata;
          prod <= a_val * bv_rdata;
          state <= S_WADD;
        end
        S_WADD: begin
          if (bk_ok && !touched[bk_c]) begin
            touched[bk_c] <= 1'b1;
            head <= {1'b0, bk_c};
            tcount <= tcount + 1'b1;
          end
          kk <= kk + 1'b1;
          state <= (kk + 1'b1 < kend) ? S_WRD : S_IDLE;
        end
        S_FRD: begin
          if (fcount < tcount && head < (CW + 1)'(MAX_COLS)) state <= S_FCHK;
          else if (!emitted) begin
            res <= '{nnz_so_far: product_nnz, is_entry: 1'b0, out_value: '0,
                     out_column: '0};
            res_last <= 1'b1;
            m_tvalid <= 1'b1;
            state <= S_CLR;
          end else begin
            // list done: release the held item as last
            res_last <= 1'b1;
            m_tvalid <= 1'b1;
            state <= S_CLR;
          end
        end
        S_FCHK: begin
          touched[head_c] <= 1'b0;
          head <= lk_rdata;
          fcount <= fcount + 1'b1;
          if (ps_rdata != '0) begin
            product_nnz <= product_nnz + 1'b1;
            if (!emitted) begin
              res <= '{nnz_so_far: product_nnz + 1'b1, is_entry: 1'b1,
                       out_value: ps_rdata, out_column: ColW'(head_c)};
              res_last <= 1'b0;
              emitted <= 1'b1;
              state <= S_FRD;
            end else begin
              // send the held item, keep the new one
              pend <= '{nnz_so_far: product_nnz + 1'b1, is_entry: 1'b1,
                        out_value: ps_rdata, out_column: ColW'(head_c)};
              m_tvalid <= 1'b1;
              state <= S_OUT;
            end
          end else state <= S_FRD;
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            res <= pend;
            state <= S_FRD;
          end
        end
        S_CLR: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b0;
            touched <= '0;
            head <= (CW + 1)'(MAX_COLS);
            tcount <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {1'b0, res};
  assign m_tlast = res_last;

  property p_ready_idle;
    @(posedge clk) disable iff (rst) s_tready |-> !m_tvalid;
  endproperty
  assert property (p_ready_idle) else $error("ready with pending result");
  assert property (@(posedge clk) disable iff (rst) tcount <= (CW + 1)'(MAX_COLS))
    else $error("touch count overflow");
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");
endmodule

// ----- src/csm_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module csm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
